// ===== hw/rtl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg: shared types, codes and the CRC7 step
// Item and result records, status and register codes, and the byte-wide
// CRC7 update (x^7 + x^3 + 1, MSB first) used by the command engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  // item kinds
  localparam logic KindStart = 1'b0;
  localparam logic KindRx    = 1'b1;

  // completion status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatTimeout  = 2'd1;
  localparam logic [1:0] StatModeErr  = 2'd2;
  localparam logic [1:0] StatCrcFail  = 2'd3;

  // configuration register indexes
  localparam logic CfgPollLimit = 1'b0;
  localparam logic CfgCheckCrc  = 1'b1;

  // register read framing
  localparam logic [4:0] RegisterBytes = 5'd15;
  localparam logic [7:0] StartToken    = 8'hFE;

  // frame constants
  localparam logic [7:0] CmdStartBits = 8'h40;
  localparam logic [7:0] IdleByte     = 8'hFF;
  localparam logic [6:0] CrcPoly      = 7'h09;

  typedef struct packed {
    logic        kind;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [3:0]  response_length;
    logic        register_read;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [7:0] poll_limit;  // already forced to at least one
    logic       check_crc;
  } cfg_t;

  function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[6] ^ b[k];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/sdspi_cfg.sv =====
// ----------------------------------------------------------------------------
// sdspi_cfg: configuration registers
// Holds poll limit and CRC check enable; presents a zero poll limit as one.
// ----------------------------------------------------------------------------
module sdspi_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  output sdspi_pkg::cfg_t     cfg_o
);

  logic [7:0] poll_limit_q;
  logic       check_crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= 8'd8;
      check_crc_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdspi_pkg::CfgPollLimit: poll_limit_q <= cfg_data_i;
        sdspi_pkg::CfgCheckCrc:  check_crc_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.poll_limit = (poll_limit_q == 8'd0) ? 8'd1 : poll_limit_q;
  assign cfg_o.check_crc  = check_crc_q;

endmodule

// ===== hw/rtl/sdspi_engine.sv =====
// ----------------------------------------------------------------------------
// sdspi_engine: command sequencer
// Holds the command state and computes one result per item; the state
// advances when fire_i is high.
// ----------------------------------------------------------------------------
module sdspi_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  sdspi_pkg::item_t    item_i,
  input  sdspi_pkg::cfg_t     cfg_i,
  output sdspi_pkg::result_t  res_o
);

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhFrame = 3'd1;
  localparam logic [2:0] PhResp  = 3'd2;
  localparam logic [2:0] PhMore  = 3'd3;
  localparam logic [2:0] PhToken = 3'd4;
  localparam logic [2:0] PhData  = 3'd5;
  localparam logic [2:0] PhCrcb  = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [31:0] arg_q, arg_d;
  logic [4:0]  bc_q, bc_d;
  logic [7:0]  poll_q, poll_d;
  logic [6:0]  crc_q, crc_d;
  logic [3:0]  exp_q, exp_d;
  logic        rdreg_q, rdreg_d;

  logic [7:0]  frame_byte;
  logic [7:0]  start_byte;
  logic [4:0]  bc_inc;
  logic        send, finish;
  logic        dv;
  logic [7:0]  db, tb;
  logic [1:0]  st;

  assign start_byte = sdspi_pkg::CmdStartBits | {2'b00, item_i.cmd_index};
  assign bc_inc     = bc_q + 5'd1;

  // argument byte for the current frame position, most significant first
  always_comb begin
    unique case (bc_q[2:0])
      3'd1:    frame_byte = arg_q[31:24];
      3'd2:    frame_byte = arg_q[23:16];
      3'd3:    frame_byte = arg_q[15:8];
      3'd4:    frame_byte = arg_q[7:0];
      default: frame_byte = cmd_q;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    arg_d   = arg_q;
    bc_d    = bc_q;
    poll_d  = poll_q;
    crc_d   = crc_q;
    exp_d   = exp_q;
    rdreg_d = rdreg_q;
    send    = 1'b0;
    finish  = 1'b0;
    dv      = 1'b0;
    db      = 8'd0;
    tb      = sdspi_pkg::IdleByte;
    st      = sdspi_pkg::StatOk;

    if (item_i.kind == sdspi_pkg::KindStart) begin
      // restart: drop whatever runs and send the command byte
      cmd_d   = start_byte;
      arg_d   = item_i.argument;
      crc_d   = sdspi_pkg::crc7_byte(7'd0, start_byte);
      exp_d   = item_i.response_length;
      rdreg_d = item_i.register_read;
      poll_d  = 8'd0;
      bc_d    = 5'd1;
      phase_d = PhFrame;
      send    = 1'b1;
      tb      = start_byte;
    end else begin
      unique case (phase_q)
        PhFrame: begin
          send = 1'b1;
          if (bc_q < 5'd5) begin
            tb    = frame_byte;
            crc_d = sdspi_pkg::crc7_byte(crc_q, frame_byte);
            bc_d  = bc_inc;
          end else if (bc_q == 5'd5) begin
            tb   = {crc_q, 1'b1};
            bc_d = bc_inc;
          end else begin
            poll_d  = 8'd1;
            phase_d = PhResp;
          end
        end
        PhResp: begin
          if (item_i.rx_byte != sdspi_pkg::IdleByte) begin
            if (rdreg_q) begin
              if (item_i.rx_byte != 8'd0) begin
                finish = 1'b1;
                st     = sdspi_pkg::StatModeErr;
              end else begin
                poll_d  = 8'd1;
                phase_d = PhToken;
                send    = 1'b1;
              end
            end else begin
              dv   = 1'b1;
              db   = item_i.rx_byte;
              bc_d = 5'd1;
              if (exp_q <= 4'd1) begin
                finish = 1'b1;
              end else begin
                phase_d = PhMore;
                send    = 1'b1;
              end
            end
          end else if (poll_q < cfg_i.poll_limit) begin
            poll_d = poll_q + 8'd1;
            send   = 1'b1;
          end else begin
            finish = 1'b1;
            st     = sdspi_pkg::StatTimeout;
          end
        end
        PhMore: begin
          dv   = 1'b1;
          db   = item_i.rx_byte;
          bc_d = bc_inc;
          if (bc_inc >= {1'b0, exp_q}) begin
            finish = 1'b1;
          end else begin
            send = 1'b1;
          end
        end
        PhToken: begin
          if (item_i.rx_byte == sdspi_pkg::StartToken) begin
            bc_d    = 5'd0;
            crc_d   = 7'd0;
            phase_d = PhData;
            send    = 1'b1;
          end else if (poll_q < cfg_i.poll_limit) begin
            poll_d = poll_q + 8'd1;
            send   = 1'b1;
          end else begin
            finish = 1'b1;
            st     = sdspi_pkg::StatTimeout;
          end
        end
        PhData: begin
          dv    = 1'b1;
          db    = item_i.rx_byte;
          crc_d = sdspi_pkg::crc7_byte(crc_q, item_i.rx_byte);
          bc_d  = bc_inc;
          if (bc_inc >= sdspi_pkg::RegisterBytes) begin
            phase_d = PhCrcb;
          end
          send = 1'b1;
        end
        PhCrcb: begin
          finish = 1'b1;
          if (!item_i.rx_byte[0]) begin
            st = sdspi_pkg::StatCrcFail;
          end else if (cfg_i.check_crc && (item_i.rx_byte[7:1] != crc_q)) begin
            st = sdspi_pkg::StatCrcFail;
          end
        end
        default: ;  // idle: ignore received bytes
      endcase
    end

    if (finish) begin
      phase_d = PhIdle;
    end
  end

  assign res_o.tx_valid    = !finish && send;
  assign res_o.chip_select = !finish && send;
  assign res_o.tx_byte     = (!finish && send) ? tb : sdspi_pkg::IdleByte;
  assign res_o.data_valid  = dv;
  assign res_o.data_byte   = db;
  assign res_o.done_res    = finish;
  assign res_o.status      = st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cmd_q   <= 8'd0;
      arg_q   <= 32'd0;
      bc_q    <= 5'd0;
      poll_q  <= 8'd0;
      crc_q   <= 7'd0;
      exp_q   <= 4'd0;
      rdreg_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      arg_q   <= arg_d;
      bc_q    <= bc_d;
      poll_q  <= poll_d;
      crc_q   <= crc_d;
      exp_q   <= exp_d;
      rdreg_q <= rdreg_d;
    end
  end

endmodule

// ===== hw/rtl/sd_spi_command_engine.sv =====
// ----------------------------------------------------------------------------
// sd_spi_command_engine: SD card SPI-mode command engine
// Sends the six-byte command frame, polls for R1 and the start token, and
// delivers response or register bytes with a completion status.
// ----------------------------------------------------------------------------
//
//   channel   handshake                    payload
//   -------   --------------------------   -----------------------------------
//   in        in_valid_i / in_stall_o      kind, cmd_index, argument,
//                                          response_length, register_read,
//                                          rx_byte
//   out       out_valid_o / out_stall_i    tx_valid, tx_byte, chip_select,
//                                          data_valid, data_byte, done_res,
//                                          status
//   cfg       cfg_we_i, cfg_idx_i          cfg_data_i (poll_limit, check_crc)
//
// Each item passes through the input register and then the result register,
// one item per cycle sustained while out_stall_i is low. The engine's
// next-state logic (a byte-wide CRC7 step and the phase decode) sits
// between those two registers. Reset leaves the engine idle with poll limit
// eight and CRC checking on. A stalled result holds the result register; an
// empty input register still takes one more item, and in_stall_o rises while it holds one.
//
module sd_spi_command_engine (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [5:0]  cmd_index_i,
  input  logic [31:0] argument_i,
  input  logic [3:0]  response_length_i,
  input  logic        register_read_i,
  input  logic [7:0]  rx_byte_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        chip_select_o,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,

  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  sdspi_pkg::cfg_t    cfg;
  sdspi_pkg::item_t   item_q;
  sdspi_pkg::result_t res;
  sdspi_pkg::result_t res_q;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               out_ready;
  logic               in_accept;
  logic               fire;

  // result register frees up when empty or being taken this cycle
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  // advance the engine state exactly when an item moves into the result
  assign fire       = in_valid_q && out_ready;

  sdspi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sdspi_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || out_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register: payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.kind            <= kind_i;
      item_q.cmd_index       <= cmd_index_i;
      item_q.argument        <= argument_i;
      item_q.response_length <= response_length_i;
      item_q.register_read   <= register_read_i;
      item_q.rx_byte         <= rx_byte_i;
    end
  end

  // result register: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  // result register: payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tx_valid_o    = res_q.tx_valid;
  assign tx_byte_o     = res_q.tx_byte;
  assign chip_select_o = res_q.chip_select;
  assign data_valid_o  = res_q.data_valid;
  assign data_byte_o   = res_q.data_byte;
  assign done_res_o    = res_q.done_res;
  assign status_o      = res_q.status;

`ifndef SYNTHESIS
  // input side stalls only while both registers hold items
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a full pipeline");

  // a finished command never asks for another exchange
  a_done_no_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (!tx_valid_o && !chip_select_o))
    else $error("command done but exchange requested");

  // no exchange means the idle byte
  a_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tx_valid_o) |-> (tx_byte_o == sdspi_pkg::IdleByte))
    else $error("tx byte not idle without exchange");

  // status is only reported with completion
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> (status_o == sdspi_pkg::StatOk))
    else $error("status set before command done");
`endif

endmodule

// ===== dv/sd_spi_command_engine_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sd_spi_command_engine_checker: exchange predictor and result scoreboard
// Watches the item, result and register ports of the command engine. For
// every accepted item it works out the reply the engine owes and queues it.
// Every accepted result is then compared field by field against the oldest
// queued reply.
// ----------------------------------------------------------------------------
module sd_spi_command_engine_checker (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  logic [5:0]  cmd_index_i,
  input  logic [31:0] argument_i,
  input  logic [3:0]  response_length_i,
  input  logic        register_read_i,
  input  logic [7:0]  rx_byte_i,

  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        tx_valid_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        chip_select_i,
  input  logic        data_valid_i,
  input  logic [7:0]  data_byte_i,
  input  logic        done_res_i,
  input  logic [1:0]  status_i,

  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,

  output int          errors_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    EngIdle, EngFrame, EngResp, EngMore, EngToken, EngData, EngCrc
  } eng_phase_e;

  // predicted engine state
  eng_phase_e  eng_phase;
  logic [39:0] frame_q;
  logic [4:0]  cnt_q;
  logic [7:0]  polls_q;
  logic [6:0]  crc_q;
  logic [3:0]  len_q;
  logic        reg_mode_q;
  // register copies
  logic [7:0]  lim_q;
  logic        crc_on_q;

  sdspi_pkg::result_t reply_q[$];
  sdspi_pkg::result_t want_reply;
  sdspi_pkg::result_t got_reply;
  sdspi_pkg::result_t new_reply;
  sdspi_pkg::item_t   seen_item;
  int          errors = 0;
  int          waiting = 0;

  assign errors_o  = errors;
  assign pending_o = waiting;

  function automatic logic [6:0] crc7_step(input logic [6:0] acc, input logic [7:0] data);
    logic [6:0] c;
    c = acc;
    for (int k = 7; k >= 0; k--) begin
      if (c[6] ^ data[k]) c = {c[5:0], 1'b0} ^ sdspi_pkg::CrcPoly;
      else c = {c[5:0], 1'b0};
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Advance the predicted engine by one item and return the reply it owes.
  task automatic next_exchange(input sdspi_pkg::item_t it, output sdspi_pkg::result_t reply);
    logic       send, finish, tv, dv, dn;
    logic [7:0] r, lim, tx, db;
    logic [1:0] st;
    int         pos;
    send = 1'b0;
    finish = 1'b0;
    tv = 1'b0;
    dv = 1'b0;
    dn = 1'b0;
    tx = sdspi_pkg::IdleByte;
    db = 8'h00;
    st = sdspi_pkg::StatOk;
    r = it.rx_byte;
    lim = (lim_q == 8'd0) ? 8'd1 : lim_q;
    if (it.kind == sdspi_pkg::KindStart) begin
      frame_q = {sdspi_pkg::CmdStartBits | {2'b00, it.cmd_index}, it.argument};
      crc_q = 7'd0;
      for (int i = 0; i < 5; i++) crc_q = crc7_step(crc_q, frame_q[39 - 8 * i -: 8]);
      len_q = it.response_length;
      reg_mode_q = it.register_read;
      polls_q = 8'd0;
      cnt_q = 5'd1;
      eng_phase = EngFrame;
      send = 1'b1;
      tx = frame_q[39:32];
    end else begin
      case (eng_phase)
        EngFrame: begin
          send = 1'b1;
          if (cnt_q < 5'd5) begin
            pos = 39 - 8 * int'(cnt_q);
            tx = frame_q[pos -: 8];
            cnt_q++;
          end else if (cnt_q == 5'd5) begin
            tx = {crc_q, 1'b1};
            cnt_q++;
          end else begin
            polls_q = 8'd1;
            eng_phase = EngResp;
          end
        end
        EngResp: begin
          if (r != sdspi_pkg::IdleByte) begin
            if (reg_mode_q) begin
              if (r != 8'h00) begin
                finish = 1'b1;
                st = sdspi_pkg::StatModeErr;
              end else begin
                polls_q = 8'd1;
                eng_phase = EngToken;
                send = 1'b1;
              end
            end else begin
              dv = 1'b1;
              db = r;
              cnt_q = 5'd1;
              if (cnt_q >= len_q) finish = 1'b1;
              else begin
                eng_phase = EngMore;
                send = 1'b1;
              end
            end
          end else if (polls_q < lim) begin
            polls_q++;
            send = 1'b1;
          end else begin
            finish = 1'b1;
            st = sdspi_pkg::StatTimeout;
          end
        end
        EngMore: begin
          dv = 1'b1;
          db = r;
          cnt_q++;
          if (cnt_q >= len_q) finish = 1'b1;
          else send = 1'b1;
        end
        EngToken: begin
          if (r == sdspi_pkg::StartToken) begin
            cnt_q = 5'd0;
            crc_q = 7'd0;
            eng_phase = EngData;
            send = 1'b1;
          end else if (polls_q < lim) begin
            polls_q++;
            send = 1'b1;
          end else begin
            finish = 1'b1;
            st = sdspi_pkg::StatTimeout;
          end
        end
        EngData: begin
          dv = 1'b1;
          db = r;
          crc_q = crc7_step(crc_q, r);
          cnt_q++;
          if (cnt_q >= sdspi_pkg::RegisterBytes) eng_phase = EngCrc;
          send = 1'b1;
        end
        EngCrc: begin
          finish = 1'b1;
          if (!r[0]) st = sdspi_pkg::StatCrcFail;
          else if (crc_on_q && (r[7:1] != crc_q)) st = sdspi_pkg::StatCrcFail;
        end
        default: begin
        end
      endcase
    end
    if (finish) begin
      eng_phase = EngIdle;
      dn = 1'b1;
    end else if (send) begin
      tv = 1'b1;
    end
    if (!tv) tx = sdspi_pkg::IdleByte;
    reply = '{tv, tx, tv, dv, db, dn, st};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_phase = EngIdle;
      frame_q = '0;
      cnt_q = '0;
      polls_q = '0;
      crc_q = '0;
      len_q = '0;
      reg_mode_q = 1'b0;
      lim_q = 8'd8;
      crc_on_q = 1'b1;
      reply_q.delete();
      waiting = 0;
    end else begin
      // retire a result first: anything accepted at this edge is still in flight
      if (out_valid_i && !out_stall_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want_reply = reply_q.pop_front();
          got_reply = '{tx_valid_i, tx_byte_i, chip_select_i, data_valid_i, data_byte_i,
                        done_res_i, status_i};
          check_field("tx_valid", got_reply.tx_valid, want_reply.tx_valid);
          check_field("tx_byte", got_reply.tx_byte, want_reply.tx_byte);
          check_field("chip_select", got_reply.chip_select, want_reply.chip_select);
          check_field("data_valid", got_reply.data_valid, want_reply.data_valid);
          check_field("data_byte", got_reply.data_byte, want_reply.data_byte);
          check_field("done_res", got_reply.done_res, want_reply.done_res);
          check_field("status", got_reply.status, want_reply.status);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sdspi_pkg::CfgPollLimit: lim_q = cfg_data_i;
          sdspi_pkg::CfgCheckCrc:  crc_on_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        seen_item = '{kind_i, cmd_index_i, argument_i, response_length_i, register_read_i,
                      rx_byte_i};
        next_exchange(seen_item, new_reply);
        reply_q.push_back(new_reply);
      end
      waiting = reply_q.size();
    end
  end

endmodule

// ===== dv/tb_sd_spi_command_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sd_spi_command_engine: regression for the SD SPI command engine
// Drives command and received-byte items through the engine under several
// poll-limit / CRC-check settings and idling mixes. A checker beside the
// engine predicts every reply and counts mismatches; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_sd_spi_command_engine;

  localparam int PhaseItems = 55;   // counted items per setting
  localparam int NumPhases  = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = sdspi_pkg::KindRx;
  logic [5:0]  cmd_index = '0;
  logic [31:0] argument = '0;
  logic [3:0]  response_length = '0;
  logic        register_read = 1'b0;
  logic [7:0]  rx_byte = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        chip_select;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic        done_res;
  logic [1:0]  status;

  logic        cfg_we = 1'b0;
  logic        cfg_idx = sdspi_pkg::CfgPollLimit;
  logic [7:0]  cfg_data = '0;

  int          errors;
  int          pending;

  // idling controls; the rates change only on a falling edge while the engine is idle
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        burst = 1'b0;
  int          quiet_left = 0;

  // what the stimulus believes is programmed
  logic [7:0]  poll_limit_set = 8'd8;

  int          n_items = 0;
  int          n_noise = 0;
  int          n_cmds = 0;
  int          n_reg_cmds = 0;
  int          n_crc_faults = 0;
  int          n_settings = 1;

  always #10 clk_i = ~clk_i;

  sd_spi_command_engine u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .kind_i            (kind),
    .cmd_index_i       (cmd_index),
    .argument_i        (argument),
    .response_length_i (response_length),
    .register_read_i   (register_read),
    .rx_byte_i         (rx_byte),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .tx_valid_o        (tx_valid),
    .tx_byte_o         (tx_byte),
    .chip_select_o     (chip_select),
    .data_valid_o      (data_valid),
    .data_byte_o       (data_byte),
    .done_res_o        (done_res),
    .status_o          (status),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data)
  );

  sd_spi_command_engine_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .kind_i            (kind),
    .cmd_index_i       (cmd_index),
    .argument_i        (argument),
    .response_length_i (response_length),
    .register_read_i   (register_read),
    .rx_byte_i         (rx_byte),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .tx_valid_i        (tx_valid),
    .tx_byte_i         (tx_byte),
    .chip_select_i     (chip_select),
    .data_valid_i      (data_valid),
    .data_byte_i       (data_byte),
    .done_res_i        (done_res),
    .status_i          (status),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .errors_o          (errors),
    .pending_o         (pending)
  );

  // Receiver: stall at the phase's rate, with the odd quiet stretch of no
  // stalling at all so bursts of back-to-back results get through too.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (quiet_left > 0) begin
      quiet_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(199) == 0) begin
      quiet_left = $urandom_range(40, 10);
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Present one item, idling beforehand at the phase's rate unless in a burst,
  // and hold it until the engine takes it. Returns on the accepting edge.
  task automatic drive_item(input sdspi_pkg::item_t it);
    while (!burst && ($urandom_range(99) < idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid        <= 1'b1;
    kind            <= it.kind;
    cmd_index       <= it.cmd_index;
    argument        <= it.argument;
    response_length <= it.response_length;
    register_read   <= it.register_read;
    rx_byte         <= it.rx_byte;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n_items++;
  endtask

  // Received byte; the command fields are don't-care, so scramble them.
  task automatic send_rx(input logic [7:0] b);
    sdspi_pkg::item_t it;
    it = '{sdspi_pkg::KindRx, 6'($urandom_range(63)), $urandom(), 4'($urandom_range(15)),
           1'($urandom_range(1)), b};
    drive_item(it);
  endtask

  task automatic send_start(input logic [5:0] idx, input logic [31:0] arg,
                            input logic [3:0] len, input logic rd);
    sdspi_pkg::item_t it;
    it = '{sdspi_pkg::KindStart, idx, arg, len, rd, 8'($urandom_range(255))};
    drive_item(it);
    n_cmds++;
    if (rd) n_reg_cmds++;
  endtask

  // Polls before the awaited byte: usually a few, sometimes anywhere below
  // the limit, and now and then all of them so the wait times out.
  function automatic int pick_polls(input int limit);
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return limit;
    if (roll < 12) return $urandom_range(limit - 1, 0);
    return $urandom_range((limit - 1 < 3) ? limit - 1 : 3, 0);
  endfunction

  // One command as a card would answer it, occasionally cut short so the
  // next start drops it mid-flight.
  task automatic run_command();
    logic [7:0] seq[$];
    logic [7:0] b;
    logic [6:0] crc;
    logic       rd;
    int         limit, len, polls, cut;
    limit = (poll_limit_set == 8'd0) ? 1 : int'(poll_limit_set);
    rd = ($urandom_range(2) == 0);
    len = ($urandom_range(4) == 0) ? $urandom_range(15, 0) : $urandom_range(8, 1);
    burst = ($urandom_range(4) == 0);
    send_start(6'($urandom_range(63)), $urandom(), len[3:0], rd);
    // five more frame exchanges plus the one that launches the first poll
    repeat (6) seq.push_back(8'($urandom_range(255)));
    polls = pick_polls(limit);
    repeat (polls) seq.push_back(sdspi_pkg::IdleByte);
    if (polls < limit) begin
      if (!rd) begin
        seq.push_back(8'($urandom_range(254)));
        repeat (((len > 1) ? len : 1) - 1) seq.push_back(8'($urandom_range(255)));
      end else if ($urandom_range(7) == 0) begin
        // nonzero R1 in register mode ends with a mode error
        seq.push_back(8'($urandom_range(254, 1)));
      end else begin
        seq.push_back(8'h00);
        polls = pick_polls(limit);
        repeat (polls) begin
          b = 8'($urandom_range(255));
          if (b == sdspi_pkg::StartToken) b = sdspi_pkg::IdleByte;
          seq.push_back(b);
        end
        if (polls < limit) begin
          seq.push_back(sdspi_pkg::StartToken);
          crc = 7'd0;
          repeat (sdspi_pkg::RegisterBytes) begin
            b = 8'($urandom_range(255));
            crc = sdspi_pkg::crc7_byte(crc, b);
            seq.push_back(b);
          end
          b = {crc, 1'b1};
          case ($urandom_range(7))
            0: b[0] = 1'b0;                                        // bad end bit
            1: b[7:1] = b[7:1] ^ (7'h01 << $urandom_range(6));     // bad CRC7
            default: ;
          endcase
          if (b != {crc, 1'b1}) n_crc_faults++;
          seq.push_back(b);
        end
      end
    end
    cut = ($urandom_range(9) == 0) ? $urandom_range(seq.size() - 1, 0) : seq.size();
    for (int i = 0; i < cut; i++) send_rx(seq[i]);
    burst = 1'b0;
  endtask

  // Stray bytes, mostly landing on an idle engine.
  task automatic send_noise();
    int n;
    n = $urandom_range(3, 1);
    repeat (n) begin
      send_rx(8'($urandom_range(255)));
      n_noise++;
    end
  endtask

  // Drop valid, wait out every expected result plus the pipeline depth.
  // Returns on a falling edge.
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  initial begin
    int start_count;
    logic [7:0] pl;
    logic       cc;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bytes on an idle engine, extreme frame fields with a zero
    // response length, a start that drops a busy command, two-byte response.
    send_rx(8'h00);
    send_rx(sdspi_pkg::IdleByte);
    send_start(6'h3F, 32'hFFFF_FFFF, 4'd0, 1'b0);
    repeat (6) send_rx(8'($urandom_range(255)));
    send_rx(8'h00);
    send_start(6'h00, 32'h0000_0000, 4'd15, 1'b0);
    send_rx(8'hA5);
    send_rx(8'h5A);
    send_start(6'h2A, 32'h8000_0001, 4'd2, 1'b0);
    repeat (6) send_rx(8'($urandom_range(255)));
    send_rx(8'h01);
    send_rx(sdspi_pkg::StartToken);

    // random under reset settings, no idling
    start_count = n_items - n_noise;
    while (n_items - n_noise - start_count < PhaseItems) begin
      if ($urandom_range(9) < 2) send_noise();
      else run_command();
    end

    for (int p = 0; p < NumPhases; p++) begin
      quiesce();
      case (p)
        0: begin pl = 8'd1;   cc = 1'b0; end
        1: begin pl = 8'd255; cc = 1'b1; end
        2: begin pl = 8'd0;   cc = 1'b1; end
        3: begin pl = 8'd3;   cc = 1'b0; end
        4: begin pl = 8'd8;   cc = 1'b1; end
        5: begin pl = 8'd2;   cc = 1'b1; end
        6: begin pl = 8'd255; cc = 1'b0; end
        default: begin pl = 8'd5; cc = 1'b1; end
      endcase
      // rotate the idling mix: none, sender, receiver, both lightly
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      @(posedge clk_i);
      write_reg(sdspi_pkg::CfgPollLimit, pl);
      write_reg(sdspi_pkg::CfgCheckCrc, {7'd0, cc});
      cfg_we <= 1'b0;
      poll_limit_set = pl;
      n_settings++;

      start_count = n_items - n_noise;
      while (n_items - n_noise - start_count < PhaseItems) begin
        if ($urandom_range(9) < 2) send_noise();
        else run_command();
      end
    end

    quiesce();
    $display("covered %0d items (%0d stray) in %0d commands, %0d register reads,",
             n_items, n_noise, n_cmds, n_reg_cmds);
    $display("%0d corrupted CRC bytes, over %0d register settings and four idling mixes",
             n_crc_faults, n_settings);
    if (errors == 0) begin
      $display("sd_spi_command_engine regression: pass");
    end else begin
      $display("sd_spi_command_engine regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("sd_spi_command_engine regression: fail");
    $finish;
  end

endmodule
